// File: hdl/ffl_pkg.sv
// Shared types and constants for the frame free list allocator.
// No dependencies; used by frame_free_list_allocator_core.sv.

package ffl_pkg;

   localparam int MaxFrames  = 4096;
   localparam int IdxWidth   = $clog2(MaxFrames);
   localparam int LinkWidth  = IdxWidth + 1;
   localparam int FrameWidth = 20;
   localparam int CountWidth = 13;

   localparam logic [LinkWidth-1:0]  LinkNull   = LinkWidth'(MaxFrames);
   localparam logic [CountWidth-1:0] CountLimit = CountWidth'(MaxFrames);

   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_MULTI   = 3'd2,
      ST_NOINIT  = 3'd3,
      ST_IGNORED = 3'd4,
      ST_TOOBIG  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REG_BASE     = 2'd0,
      REG_COUNT    = 2'd1,
      REG_RESERVED = 2'd2
   } reg_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_LOOKUP,
      S_FINISH
   } state_type;

endpackage

// File: hdl/ffl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module ffl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: hdl/frame_free_list_allocator_core.sv
// Top level of the frame free list allocator: control sequencer, registers
// and link memory. Depends on ffl_pkg and ffl_ram.
//
// Usage:
//   req channel carries one transaction per command: init, allocate or free.
//   rsp channel returns exactly one transaction per command, in order, with
//   the granted absolute frame number (zero unless an allocate succeeded)
//   and a status code.
//   csr is an APB-style port holding base_frame, frame_count and
//   reserved_frames at byte addresses 0, 4 and 8; write it only while idle.
// Sequencing (one command in flight at a time):
//   free or refused command: accept, then the finish step loads the result
//   into the output register.
//   allocate: accept (link read), lookup (head update, link write), then
//   result; the lookup step is set by the registered read of the link RAM.
//   init: one link RAM write per managed frame, then result.
// Reset clears the list head, the initialised flag and the output valid flag;
// the link RAM is not cleared, init writes every active entry before use.
// A stalled receiver holds the result in the output register; the next
// command is still accepted and waits at its finish step until the slot
// drains.

module frame_free_list_allocator_core (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: page_count[7:0], frame_number[27:8], zero pad [31:28]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // req_tuser: op[1:0]
   input  logic [1:0]  req_tuser,
   // rsp_tdata: granted_frame[19:0], status[22:20], zero pad [23]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW = ffl_pkg::IdxWidth;
   localparam int LW = ffl_pkg::LinkWidth;
   localparam int FW = ffl_pkg::FrameWidth;
   localparam int CW = ffl_pkg::CountWidth;

   ffl_pkg::state_type  state_ff, state_in;
   logic [LW-1:0]       head_ff, head_in;
   logic                init_ff, init_in;
   logic [IW-1:0]       walk_ff, walk_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]       rsp_frame_ff, rsp_frame_in;
   ffl_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [FW-1:0]       pend_frame_ff, pend_frame_in;
   ffl_pkg::status_type pend_status_ff, pend_status_in;
   logic [FW-1:0]       base_ff, base_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       resv_ff, resv_in;

   ffl_pkg::op_type     req_op;
   logic [7:0]          req_pages;
   logic [FW-1:0]       req_frame;
   logic                accept;
   logic                out_free;
   logic [CW-1:0]       active;
   logic [CW-1:0]       last_idx;
   logic [FW-1:0]       free_diff;
   logic                free_bad;
   logic                init_toobig;
   logic                alloc_bad;
   logic [LW-1:0]       walk_next;
   logic                walk_null;
   logic                walk_last;
   logic                csr_write;
   ffl_pkg::reg_type    csr_reg;

   logic                ram_wr_en;
   logic [IW-1:0]       ram_wr_addr;
   logic [LW-1:0]       ram_wr_data;
   logic                ram_rd_en;
   logic [IW-1:0]       ram_rd_addr;
   logic [LW-1:0]       ram_rd_data;

   ffl_ram #(
      .WIDTH (LW),
      .DEPTH (ffl_pkg::MaxFrames)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_op    = ffl_pkg::op_type'(req_tuser);
   assign req_pages = req_tdata[7:0];
   assign req_frame = req_tdata[27:8];

   assign req_tready = (state_ff == ffl_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_status_ff, rsp_frame_ff};

   assign active    = (count_ff > ffl_pkg::CountLimit) ? ffl_pkg::CountLimit : count_ff;
   assign last_idx  = active - CW'(1);
   assign free_diff = req_frame - base_ff;
   assign free_bad  = (req_frame <= base_ff) || (free_diff >= FW'(active));

   assign init_toobig = (resv_ff >= active);
   assign alloc_bad   = !init_ff || (req_pages > 8'd1) || (head_ff >= ffl_pkg::LinkNull);

   assign walk_next = {1'b0, walk_ff} + LW'(1);
   assign walk_null = (CW'(walk_ff) < resv_ff) || (CW'(walk_next) >= active);
   assign walk_last = (CW'(walk_ff) == last_idx);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffl_pkg::S_IDLE: begin
            if (accept) begin
               case (req_op)
                  ffl_pkg::OP_INIT:  state_in = init_toobig ? ffl_pkg::S_FINISH
                                                            : ffl_pkg::S_WALK;
                  ffl_pkg::OP_ALLOC: state_in = alloc_bad ? ffl_pkg::S_FINISH
                                                          : ffl_pkg::S_LOOKUP;
                  default:           state_in = ffl_pkg::S_FINISH;
               endcase
            end
         end
         ffl_pkg::S_WALK: begin
            if (walk_last) state_in = ffl_pkg::S_FINISH;
         end
         ffl_pkg::S_LOOKUP: state_in = ffl_pkg::S_FINISH;
         ffl_pkg::S_FINISH: begin
            if (out_free) state_in = ffl_pkg::S_IDLE;
         end
         default: state_in = ffl_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in        = head_ff;
      init_in        = init_ff;
      walk_in        = walk_ff;
      pend_frame_in  = pend_frame_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_frame_in   = rsp_frame_ff;
      rsp_status_in  = rsp_status_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = walk_ff;
      ram_wr_data    = ffl_pkg::LinkNull;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = head_ff[IW-1:0];
      case (state_ff)
         ffl_pkg::S_IDLE: begin
            if (accept) begin
               pend_frame_in  = '0;
               pend_status_in = ffl_pkg::ST_OK;
               case (req_op)
                  ffl_pkg::OP_INIT: begin
                     walk_in = '0;
                     if (init_toobig) pend_status_in = ffl_pkg::ST_TOOBIG;
                  end
                  ffl_pkg::OP_ALLOC: begin
                     if (!init_ff) begin
                        pend_status_in = ffl_pkg::ST_NOINIT;
                     end else if (req_pages > 8'd1) begin
                        pend_status_in = ffl_pkg::ST_MULTI;
                     end else if (head_ff >= ffl_pkg::LinkNull) begin
                        pend_status_in = ffl_pkg::ST_EMPTY;
                     end else begin
                        ram_rd_en = 1'b1;
                     end
                  end
                  ffl_pkg::OP_FREE: begin
                     if (!init_ff) begin
                        pend_status_in = ffl_pkg::ST_NOINIT;
                     end else if (free_bad) begin
                        pend_status_in = ffl_pkg::ST_IGNORED;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = free_diff[IW-1:0];
                        ram_wr_data = head_ff;
                        head_in     = {1'b0, free_diff[IW-1:0]};
                     end
                  end
                  default: pend_status_in = ffl_pkg::ST_IGNORED;
               endcase
            end
         end
         ffl_pkg::S_WALK: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = walk_ff;
            ram_wr_data = walk_null ? ffl_pkg::LinkNull : walk_next;
            walk_in     = walk_ff + IW'(1);
            if (walk_last) begin
               head_in = LW'(resv_ff);
               init_in = 1'b1;
            end
         end
         ffl_pkg::S_LOOKUP: begin
            head_in       = ram_rd_data;
            ram_wr_en     = 1'b1;
            ram_wr_addr   = head_ff[IW-1:0];
            ram_wr_data   = ffl_pkg::LinkNull;
            pend_frame_in = base_ff + FW'(head_ff[IW-1:0]);
         end
         ffl_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_frame_in  = pend_frame_ff;
               rsp_status_in = pend_status_ff;
            end
         end
         default: ;
      endcase
   end

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = ffl_pkg::reg_type'(csr_paddr[3:2]);

   always_comb begin
      base_in  = base_ff;
      count_in = count_ff;
      resv_in  = resv_ff;
      if (csr_write) begin
         case (csr_reg)
            ffl_pkg::REG_BASE:     base_in  = csr_pwdata[FW-1:0];
            ffl_pkg::REG_COUNT:    count_in = csr_pwdata[CW-1:0];
            ffl_pkg::REG_RESERVED: resv_in  = csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         ffl_pkg::REG_BASE:     csr_prdata = 32'(base_ff);
         ffl_pkg::REG_COUNT:    csr_prdata = 32'(count_ff);
         ffl_pkg::REG_RESERVED: csr_prdata = 32'(resv_ff);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffl_pkg::S_IDLE;
         head_ff      <= ffl_pkg::LinkNull;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         count_ff     <= CW'(4096);
         resv_ff      <= CW'(1);
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         resv_ff      <= resv_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff        <= walk_in;
      pend_frame_ff  <= pend_frame_in;
      pend_status_ff <= pend_status_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_status_ff  <= rsp_status_in;
   end

endmodule
